[design/irfc_pkg.sv]
// Shared types and constants for the inverter reply frame checker.
`timescale 1ns / 1ps

package irfc_pkg;

  // Frame bound in bytes: a frame, terminator included, must be shorter than this.
  localparam int unsigned MaxFrame = 128;
  localparam int unsigned CountW   = $clog2(MaxFrame);

  // Request kinds carried on the input tuser.
  localparam logic [1:0] OpCmd  = 2'd0;
  localparam logic [1:0] OpPoll = 2'd1;
  localparam logic [1:0] OpByte = 2'd2;
  localparam logic [1:0] OpTick = 2'd3;

  // Result status codes.
  localparam logic [2:0] StCmdAck     = 3'd0;
  localparam logic [2:0] StCmdNoAck   = 3'd1;
  localparam logic [2:0] StCmdCrcBad  = 3'd2;
  localparam logic [2:0] StCmdLenBad  = 3'd3;
  localparam logic [2:0] StPollOk     = 3'd4;
  localparam logic [2:0] StPollNak    = 3'd5;
  localparam logic [2:0] StPollCrcBad = 3'd6;
  localparam logic [2:0] StTimeout    = 3'd7;

  // Configuration register indexes (word address).
  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegPoly    = 2'd1;
  localparam logic [1:0] RegInit    = 2'd2;

  localparam logic [15:0] TimeoutRst = 16'd1000;
  localparam logic [15:0] PolyRst    = 16'h1021;
  localparam logic [15:0] InitRst    = 16'h0000;

  // Packed so that status sits in the low bits.
  typedef struct packed {
    logic [6:0] payload_length;
    logic       was_poll;
    logic [2:0] status;
  } irfc_result_t;

endpackage

[design/inverter_reply_frame_checker_core.sv]
// Flow: an accepted transaction is held in the input register and checked there; its status,
// if any, is registered into the output buffer, whose head drives the master side.
// Throughput: one transaction per cycle unless both output slots are full; the CRC byte update is a
// combinational eight-step shift network and a two-entry output buffer absorbs stalls.
// Reset (rst_ni low, asynchronous) empties all stages, closes any wait and loads
// the register defaults; no clearing pass follows.
`timescale 1ns / 1ps

module inverter_reply_frame_checker_core
  import irfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [2:0] status, [3] was_poll, [10:4] payload_length
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] timeout_q, poly_q, init_q;
  logic        cfg_wr;

  logic        in_valid_q;
  logic [1:0]  in_op_q;
  logic [7:0]  in_byte_q;
  logic        proc_en;

  logic         res_valid;
  irfc_result_t res;

  logic         out_valid_q, sk_valid_q;
  irfc_result_t out_q, sk_q;
  logic         pop;
  logic         push;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      poly_q    <= PolyRst;
      init_q    <= InitRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegTimeout: timeout_q <= pwdata[15:0];
        RegPoly:    poly_q    <= pwdata[15:0];
        RegInit:    init_q    <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegTimeout: prdata = {16'd0, timeout_q};
      RegPoly:    prdata = {16'd0, poly_q};
      RegInit:    prdata = {16'd0, init_q};
      default:    prdata = '0;
    endcase
  end

  // input register; processing stalls only when both output slots are full
  assign proc_en         = in_valid_q && !sk_valid_q;
  assign s_axis_tready_o = !in_valid_q || proc_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  irfc_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (proc_en),
    .op_i            (in_op_q),
    .rx_byte_i       (in_byte_q),
    .timeout_ticks_i (timeout_q),
    .crc_poly_i      (poly_q),
    .crc_init_i      (init_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // two-entry output buffer: head drives the port, skid catches a stalled result
  assign pop  = out_valid_q && m_axis_tready_i;
  assign push = res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (pop) begin
      if (sk_valid_q) begin
        sk_valid_q <= push;
      end else begin
        out_valid_q <= push;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= push;
    end else if (push) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (sk_valid_q) begin
        out_q <= sk_q;
        if (push) begin
          sk_q <= res;
        end
      end else if (push) begin
        out_q <= res;
      end
    end else if (!out_valid_q) begin
      if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      sk_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty head");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && sk_valid_q)
    else $error("input stalled with room in the output buffer");
  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && sk_valid_q |=> in_valid_q && $stable(in_op_q) && $stable(in_byte_q))
    else $error("pending transaction lost while output full");
`endif

endmodule

[design/irfc_frame.sv]
// Frame state and per-transaction checking: CRC, length, ACK/NAK and timeout.
`timescale 1ns / 1ps

module irfc_frame
  import irfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [1:0]   op_i,
  input  logic [7:0]   rx_byte_i,
  input  logic [15:0]  timeout_ticks_i,
  input  logic [15:0]  crc_poly_i,
  input  logic [15:0]  crc_init_i,
  output logic         res_valid_o,
  output irfc_result_t res_o
);

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeCmd  = 2'd1;
  localparam logic [1:0] ModePoll = 2'd2;

  localparam logic [7:0] EndMark = 8'h0D;
  localparam logic [CountW-1:0] CntLast = CountW'(MaxFrame - 1);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] bump(input logic [7:0] b);
    if (b == 8'h28 || b == 8'h0D || b == 8'h0A) begin
      return b + 8'd1;
    end
    return b;
  endfunction

  logic [1:0]        mode_q, mode_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [15:0]       crc_q, crc_d;
  logic [1:0][7:0]   held_q, held_d;
  logic [3:0][7:0]   head_q, head_d;
  logic [15:0]       tick_q, tick_d;

  logic              has_res;
  logic              clear;
  logic [2:0]        status;
  logic [CountW-1:0] payload;
  logic              have_pair;
  logic              crc_ok;
  logic              is_ack;
  logic              is_nak;
  logic              waiting;

  assign waiting   = (mode_q == ModeCmd) || (mode_q == ModePoll);
  assign have_pair = cnt_q >= CountW'(2);
  assign payload   = have_pair ? cnt_q - CountW'(2) : '0;
  assign crc_ok    = have_pair && (bump(crc_q[15:8]) == held_q[0])
                     && (bump(crc_q[7:0]) == held_q[1]);
  assign is_ack    = (head_q[1] == "A") && (head_q[2] == "C") && (head_q[3] == "K");
  assign is_nak    = (payload >= CountW'(4)) && (head_q[0] == "(") && (head_q[1] == "N")
                     && (head_q[2] == "A") && (head_q[3] == "K");

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    held_d  = held_q;
    head_d  = head_q;
    tick_d  = tick_q;
    has_res = 1'b0;
    clear   = 1'b0;
    status  = StTimeout;
    if (en_i) begin
      case (op_i)
        OpCmd: begin
          mode_d = ModeCmd;
          tick_d = '0;
          clear  = 1'b1;
        end
        OpPoll: begin
          mode_d = ModePoll;
          tick_d = '0;
          clear  = 1'b1;
        end
        OpTick: begin
          if (waiting) begin
            if (tick_q >= timeout_ticks_i) begin
              has_res = 1'b1;
              status  = StTimeout;
            end else begin
              tick_d = tick_q + 16'd1;
            end
          end
        end
        default: begin
          if (waiting) begin
            if (cnt_q == CntLast) begin
              // overlong: drop the byte and start the frame over, wait stays open
              clear = 1'b1;
            end else if (rx_byte_i != EndMark) begin
              if (cnt_q < CountW'(4)) begin
                head_d[cnt_q[1:0]] = rx_byte_i;
              end
              if (have_pair) begin
                crc_d = crc_feed(crc_q, held_q[0], crc_poly_i);
              end
              held_d[0] = held_q[1];
              held_d[1] = rx_byte_i;
              cnt_d     = cnt_q + CountW'(1);
            end else begin
              has_res = 1'b1;
              if (mode_q == ModeCmd) begin
                if (!have_pair || payload != CountW'(4)) begin
                  status = StCmdLenBad;
                end else if (!crc_ok) begin
                  status = StCmdCrcBad;
                end else if (is_ack) begin
                  status = StCmdAck;
                end else begin
                  status = StCmdNoAck;
                end
              end else begin
                if (!crc_ok) begin
                  status = StPollCrcBad;
                end else if (is_nak) begin
                  status = StPollNak;
                end else begin
                  status = StPollOk;
                end
              end
            end
          end
        end
      endcase
    end
    if (has_res) begin
      mode_d = ModeIdle;
      tick_d = '0;
      clear  = 1'b1;
    end
    if (clear) begin
      cnt_d  = '0;
      crc_d  = crc_init_i;
      held_d = '0;
      head_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      cnt_q  <= '0;
      crc_q  <= InitRst;
      held_q <= '0;
      head_q <= '0;
      tick_q <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      held_q <= held_d;
      head_q <= head_d;
      tick_q <= tick_d;
    end
  end

  assign res_valid_o          = has_res;
  assign res_o.status         = status;
  assign res_o.was_poll       = (mode_q == ModePoll);
  assign res_o.payload_length = (status == StTimeout) ? 7'd0 : 7'(payload);

`ifndef SYNTHESIS
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> mode_q == ModeIdle)
    else $error("wait still open after a result");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeIdle |-> cnt_q == '0 && tick_q == '0)
    else $error("frame state left over while idle");
  a_result_needs_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> waiting && (op_i == OpByte || op_i == OpTick))
    else $error("result without an open wait");
`endif

endmodule
